// ===== rtl/npc_pkg.sv =====
// Shared types and constants for the nearest palette color block.
`timescale 1ns / 1ps

package npc_pkg;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int OUT_W   = 4;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_WAIT,
        ST_RESULT,
        ST_ADD_RD,
        ST_ADD_WAIT,
        ST_CLEAR
    } npc_state_t;

    typedef struct packed {
        logic rd_en;
        logic rd_last;
        logic load;
        logic wr_en;
        logic clear;
    } npc_cmd_t;

    typedef struct packed {
        logic add_hit;
        logic add_end;
        logic find_done;
    } npc_stat_t;

endpackage

// ===== rtl/npc_ctrl.sv =====
// Controller: sequences palette scans for find and add transactions, and the clear transaction.
`timescale 1ns / 1ps

module npc_ctrl #(
    parameter int PALETTE_ENTRIES = 16,
    parameter int IDX_W           = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [npc_pkg::MODE_W-1:0] mode,
    output logic                     out_valid,
    input  logic                     out_stall,
    output npc_pkg::npc_cmd_t        cmd,
    output logic [IDX_W-1:0]         rd_addr,
    input  npc_pkg::npc_stat_t       stat
);
    import npc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] ADD_START = IDX_W'(1);

    npc_state_t       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_FIND:
                        begin
                            addr_next  = '0;
                            state_next = ST_FIND_RD;
                        end
                        MODE_ADD:
                        begin
                            addr_next  = ADD_START;
                            state_next = ST_ADD_RD;
                        end
                        MODE_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIND_RD:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_FIND_WAIT;
                end
            end
            ST_FIND_WAIT:
            begin
                if (stat.find_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_RD:
            begin
                addr_next = addr_reg + 1'b1;
                if (stat.add_hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_ADD_WAIT;
                end
            end
            ST_ADD_WAIT:
            begin
                if (stat.add_hit || stat.add_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.rd_en   = (state_reg == ST_FIND_RD) || (state_reg == ST_ADD_RD);
        cmd.rd_last = (addr_reg == LAST_ADDR);
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.wr_en   = ((state_reg == ST_ADD_RD) || (state_reg == ST_ADD_WAIT))
                      && stat.add_hit;
        cmd.clear   = (state_reg == ST_CLEAR);
        rd_addr     = addr_reg;
        in_stall    = (state_reg != ST_IDLE);
        out_valid   = (state_reg == ST_RESULT);
    end

endmodule

// ===== rtl/npc_datapath.sv =====
// Datapath: palette memory, distance pipeline and running minimum.
`timescale 1ns / 1ps

module npc_datapath #(
    parameter int PALETTE_ENTRIES = 16,
    parameter int IDX_W           = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  npc_pkg::npc_cmd_t           cmd,
    input  logic [IDX_W-1:0]            rd_addr,
    input  logic [npc_pkg::COLOR_W-1:0] color,
    output npc_pkg::npc_stat_t          stat,
    output logic [npc_pkg::OUT_W-1:0]   nearest_index
);
    import npc_pkg::*;

    logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;

    logic [COLOR_W-1:0] color_reg;

    // stage 1: registered read
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    logic [COLOR_W-1:0] s1_data_reg;
    logic               s1_vld_reg;
    logic [COLOR_W-1:0] s1_entry;

    // stage 2: per-channel squares
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [IDX_W-1:0]   s2_addr_reg;
    logic [SQ_W-1:0]    s2_sq_reg [3];

    logic [CHAN_W-1:0]  diff [3];
    logic [DIST_W-1:0]  dist_sum;

    logic [DIST_W-1:0]  best_d_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               done_reg;

    logic [IDX_W+OUT_W-1:0] idx_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[s1_addr_reg] <= color_reg;
        end
        s1_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.clear)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            color_reg <= color;
        end
        s1_addr_reg <= rd_addr;
        s1_last_reg <= cmd.rd_last;
        s1_vld_reg  <= vld_reg[rd_addr];
        s2_addr_reg <= s1_addr_reg;
        s2_last_reg <= s1_last_reg;
        for (int c = 0; c < 3; c++)
        begin
            s2_sq_reg[c] <= SQ_W'(diff[c]) * SQ_W'(diff[c]);
        end
    end

    assign s1_entry = s1_vld_reg ? s1_data_reg : '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (color_reg[c*CHAN_W +: CHAN_W] >= s1_entry[c*CHAN_W +: CHAN_W])
            begin
                diff[c] = color_reg[c*CHAN_W +: CHAN_W] - s1_entry[c*CHAN_W +: CHAN_W];
            end
            else
            begin
                diff[c] = s1_entry[c*CHAN_W +: CHAN_W] - color_reg[c*CHAN_W +: CHAN_W];
            end
        end
    end

    assign dist_sum = DIST_W'(s2_sq_reg[0]) + DIST_W'(s2_sq_reg[1]) + DIST_W'(s2_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            best_d_reg   <= '1;
            best_idx_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            // drop the tail of an add scan that stopped early
            s2_valid_reg <= s1_valid_reg && !cmd.load;
            done_reg     <= s2_valid_reg && s2_last_reg;
            if (cmd.load)
            begin
                best_d_reg   <= '1;
                best_idx_reg <= '0;
            end
            else if (s2_valid_reg && (dist_sum < best_d_reg))
            begin
                best_d_reg   <= dist_sum;
                best_idx_reg <= s2_addr_reg;
            end
        end
    end

    always_comb
    begin
        stat.add_hit   = s1_valid_reg && ((s1_entry == '0) || (s1_entry == color_reg));
        stat.add_end   = s1_valid_reg && s1_last_reg;
        stat.find_done = done_reg;
    end

    assign idx_ext       = {{OUT_W{1'b0}}, best_idx_reg};
    assign nearest_index = idx_ext[OUT_W-1:0];

endmodule

// ===== rtl/nearest_palette_color_core.sv =====
// Top level of the nearest palette color block.
//
//  channel | signals                        | payload
//  --------+--------------------------------+---------------------
//  input   | in_valid / in_stall            | mode, color
//  output  | out_valid / out_stall          | nearest_index
//
// Find: scans the palette before the result is valid, one
//   palette entry per cycle through the single memory read port.
// One transaction in flight; in_stall is high until it is finished and its
//   result has been taken. Reset empties the palette through its valid bits.
`timescale 1ns / 1ps

module nearest_palette_color_core #(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [npc_pkg::MODE_W-1:0]  mode,
    input  logic [npc_pkg::COLOR_W-1:0] color,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [npc_pkg::OUT_W-1:0]   nearest_index
);
    import npc_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    npc_cmd_t         cmd;
    npc_stat_t        stat;
    logic [IDX_W-1:0] rd_addr;

    npc_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .stat     (stat)
    );

    npc_datapath #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .IDX_W          (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .color        (color),
        .stat         (stat),
        .nearest_index(nearest_index)
    );

endmodule

// ===== rtl/npc_checker.sv =====
// Port-level checks for the nearest palette color block, bound to the top level.
`timescale 1ns / 1ps

module npc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [npc_pkg::MODE_W-1:0]  mode,
    input logic [npc_pkg::COLOR_W-1:0] color,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [npc_pkg::OUT_W-1:0]   nearest_index
);
    import npc_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(nearest_index))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (mode == MODE_ADD || mode == MODE_CLEAR) |=> !out_valid)
        else $error("result after add or clear");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (mode == MODE_FIND || mode == MODE_ADD || mode == MODE_CLEAR)
        |=> in_stall)
        else $error("not busy after transaction");

endmodule

bind nearest_palette_color_core npc_checker u_npc_checker (.*);
